FILE: sv/firc_pkg.sv
// Shared types and constants for the circular-buffer FIR filter.
// No dependencies; imported by the top level.
package firc_pkg;

  // Sample and coefficient format, signed Q1.15
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  // Full-precision Q.30 sum
  localparam int unsigned ACC_W    = 35;

  // Coefficient register file
  localparam int unsigned NUM_COEF  = 8;
  localparam int unsigned COEF_IDX_W = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } firc_state_e;

endpackage

FILE: sv/firc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; holds the filter's delay line.
module firc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/fir_filter_circular.sv
// FIR filter over a circular delay line held in a synchronous RAM.
// One multiply-accumulate per tap through the single RAM read port; a new sample is accepted
// only once the sequencer is back in idle, after the previous sum has moved to the output register.
// A finished item waits in the output register while the next item is accepted.
// Reset (rst_ni low, asynchronous) clears coefficients, write pointer, sequencer and
// per-entry valid bits; entries not yet written read as zero. No clearing pass.
module fir_filter_circular #(
  parameter int unsigned TAPS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream; tdata[15:0] = sample_in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [firc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Output stream; tdata[34:0] = filtered, [39:35] zero
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [firc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Coefficient write port
  input  logic                                 cfg_we_i,
  input  logic [firc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [firc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import firc_pkg::*;

  localparam int unsigned PW = $clog2(TAPS);
  localparam logic [PW-1:0] LAST_POS = PW'(TAPS - 1);

  firc_state_e state_q, state_d;

  coef_t           coef_q [NUM_COEF];
  logic [TAPS-1:0] tap_vld_q;
  logic [PW-1:0]   wp_q;

  // Read issue
  logic            issue_q;
  logic [PW-1:0]   ptr_q;
  logic [PW-1:0]   tap_q;

  // RAM data stage
  logic            s1_vld_q;
  logic            s1_live_q;
  logic [PW-1:0]   s1_tap_q;
  sample_t         ram_rdata;

  // Product stage
  logic            s2_vld_q;
  logic            s2_last_q;
  prod_t           prod_q;

  acc_t            acc_q;

  logic            out_vld_q;
  acc_t            out_data_q;

  logic            in_fire;
  logic            out_load;
  sample_t         mul_sample;
  coef_t           mul_coef;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Delay line storage
  firc_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TAPS)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(wp_q),
    .wdata_i(s_axis_tdata[SAMPLE_W-1:0]),
    .re_i   (issue_q),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  // Coefficient registers; writes past the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEF))) begin
      coef_q[cfg_idx_i[COEF_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (s2_vld_q && s2_last_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Write pointer, entry valid bits and read issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      tap_vld_q <= '0;
      issue_q   <= 1'b0;
      ptr_q     <= '0;
      tap_q     <= '0;
    end else if (in_fire) begin
      tap_vld_q[wp_q] <= 1'b1;
      wp_q    <= (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
      // Walk back from the entry just written
      ptr_q   <= wp_q;
      tap_q   <= '0;
      issue_q <= 1'b1;
    end else if (issue_q) begin
      ptr_q <= (ptr_q == '0) ? LAST_POS : ptr_q - 1'b1;
      tap_q <= tap_q + 1'b1;
      if (tap_q == LAST_POS) issue_q <= 1'b0;
    end
  end

  // Pipeline control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue_q;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && (s1_tap_q == LAST_POS);
    end
  end

  // Tap tag and entry validity travel beside the RAM read
  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      s1_tap_q  <= tap_q;
      s1_live_q <= tap_vld_q[ptr_q];
    end
  end

  // Multiply: unwritten entries count as zero
  assign mul_sample = s1_live_q ? ram_rdata : '0;
  assign mul_coef   = coef_q[COEF_IDX_W'(s1_tap_q)];

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= mul_sample * mul_coef;
    end
  end

  // Accumulate at full precision
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Output register: load when the finished sum can move, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - ACC_W)'(0), out_data_q};

endmodule

FILE: sv/firc_checker.sv
// Port-level checks for the circular-buffer FIR filter.
// Bound to fir_filter_circular; sees only its ports.
module firc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // One item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still in flight");

  // The sum never reaches the pad bits
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'd0))
    else $error("output pad bits not zero");

  // Nothing is presented the cycle after an accept from idle with output empty
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result presented too early");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output item changed");

endmodule

bind fir_filter_circular firc_checker u_firc_checker (.*);
